/* src/pps_pkg.sv */
package pps_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int SLOT_W        = $clog2(MAX_PROCESSES);
  localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);
  localparam int SCAN_W        = SLOT_W + 1;

  localparam int KIND_W      = 2;
  localparam int IN_SLOT_W   = 4;
  localparam int SHORT_W     = 16;
  localparam int PRIO_W      = 8;
  localparam int TIME_W      = 32;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  typedef logic [SLOT_W-1:0] idx_t;

  typedef struct packed {
    logic [SHORT_W-1:0] arrival;
    logic [SHORT_W-1:0] burst;
    logic [SHORT_W-1:0] remaining;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DEC,
    S_TURN,
    S_WAIT
  } state_t;

endpackage

/* src/preemptive_priority_scheduler_top.sv */
// Preemptive priority scheduler over a table of process slots.
// Command channel: an item is taken when start is high and busy is low.
// kind selects clear (empty the table, zero the clock), load (write one slot
// with arrival, burst and priority) or tick (run one unit of time).
// A clear takes effect at once and never raises busy. A load holds busy for
// one cycle to read the old slot entry and write the new one.
// A tick reads the slot table one entry per cycle through its single read
// port, and busy stays high through the scan and the decrement step;
// when the chosen process finishes, states S_TURN and S_WAIT form the times.
// A completion is shown on the result ports for one cycle with done high,
// in the first cycle with busy low; the receiver cannot hold it off, and a new
// item may be started in that same cycle.
// A new tick is taken only once the previous one has let busy fall.
// Synchronous reset empties the table, zeroes the clock and returns to idle;
// table entries are not cleared; every slot is read, but only valid ones count.
module preemptive_priority_scheduler_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [pps_pkg::KIND_W-1:0]     kind,
  input  logic [pps_pkg::IN_SLOT_W-1:0]  slot,
  input  logic [pps_pkg::SHORT_W-1:0]    arrival_time,
  input  logic [pps_pkg::SHORT_W-1:0]    burst_time,
  input  logic [pps_pkg::PRIO_W-1:0]     priority_level,
  output logic                           done,
  output logic [pps_pkg::IN_SLOT_W-1:0]  process_slot,
  output logic [pps_pkg::TIME_W-1:0]     completion_time,
  output logic [pps_pkg::TIME_W-1:0]     waiting_time,
  output logic [pps_pkg::TIME_W-1:0]     turnaround_time,
  output logic                           all_done
);
  import pps_pkg::*;

  mem_req_t req;
  entry_t   rdata;

  pps_table u_table (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  pps_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .kind            (kind),
    .slot            (slot),
    .arrival_time    (arrival_time),
    .burst_time      (burst_time),
    .priority_level  (priority_level),
    .req             (req),
    .rdata           (rdata),
    .done            (done),
    .process_slot    (process_slot),
    .completion_time (completion_time),
    .waiting_time    (waiting_time),
    .turnaround_time (turnaround_time),
    .all_done        (all_done)
  );

endmodule

/* src/pps_table.sv */
module pps_table (
  input  logic              clk,
  input  pps_pkg::mem_req_t req,
  output pps_pkg::entry_t   rdata
);
  import pps_pkg::*;

  entry_t mem [MAX_PROCESSES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

/* src/pps_ctrl.sv */
module pps_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [pps_pkg::KIND_W-1:0]     kind,
  input  logic [pps_pkg::IN_SLOT_W-1:0]  slot,
  input  logic [pps_pkg::SHORT_W-1:0]    arrival_time,
  input  logic [pps_pkg::SHORT_W-1:0]    burst_time,
  input  logic [pps_pkg::PRIO_W-1:0]     priority_level,
  output pps_pkg::mem_req_t              req,
  input  pps_pkg::entry_t                rdata,
  output logic                           done,
  output logic [pps_pkg::IN_SLOT_W-1:0]  process_slot,
  output logic [pps_pkg::TIME_W-1:0]     completion_time,
  output logic [pps_pkg::TIME_W-1:0]     waiting_time,
  output logic [pps_pkg::TIME_W-1:0]     turnaround_time,
  output logic                           all_done
);
  import pps_pkg::*;

  state_t               state, state_next;
  logic [MAX_PROCESSES-1:0] valid;
  logic [CNT_W-1:0]     fin_count;
  logic [CNT_W-1:0]     valid_count;
  logic [TIME_W-1:0]    current_time;
  logic [SCAN_W-1:0]    cnt;
  idx_t                 chk_idx;
  idx_t                 best_idx;
  entry_t               best;
  logic                 best_found;
  idx_t                 ld_idx;
  entry_t               ld_entry;
  logic [TIME_W-1:0]    turn;
  logic [TIME_W-1:0]    wait_t;
  logic                 all_done_r;

  logic                 in_range;
  logic                 scan_last;
  logic                 cand_ready;
  logic                 take;
  logic                 old_fin;
  logic                 finishing;
  logic [TIME_W-1:0]    time_inc;
  logic [TIME_W-1:0]    arr_ext;
  logic [TIME_W-1:0]    burst_ext;
  entry_t               best_dec;

  assign in_range   = int'(slot) < MAX_PROCESSES;
  assign scan_last  = cnt == SCAN_W'(MAX_PROCESSES);
  assign cand_ready = valid[chk_idx] && (rdata.remaining != '0)
                      && ({{(TIME_W-SHORT_W){1'b0}}, rdata.arrival} <= current_time);
  assign take       = (cnt != '0) && cand_ready && (!best_found || rdata.prio > best.prio);
  assign old_fin    = valid[ld_idx] && (rdata.remaining == '0);
  assign finishing  = best_found && (best.remaining == SHORT_W'(1));
  assign time_inc   = (current_time == '1) ? current_time : current_time + TIME_W'(1);
  assign arr_ext    = {{(TIME_W-SHORT_W){1'b0}}, best.arrival};
  assign burst_ext  = {{(TIME_W-SHORT_W){1'b0}}, best.burst};

  always_comb begin
    best_dec           = best;
    best_dec.remaining = best.remaining - SHORT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.we     = 1'b0;
    req.waddr  = ld_idx;
    req.wdata  = ld_entry;
    req.raddr  = SLOT_W'(slot);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_LOAD && in_range) begin
            state_next = S_LOAD;
          end else if (kind == KIND_TICK) begin
            state_next = S_SCAN;
          end
        end
      end
      S_LOAD: begin
        req.we     = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        req.raddr = cnt[SLOT_W-1:0];
        if (scan_last) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        req.we    = best_found;
        req.waddr = best_idx;
        req.wdata = best_dec;
        state_next = finishing ? S_TURN : S_IDLE;
      end
      S_TURN: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      fin_count    <= '0;
      valid_count  <= '0;
      current_time <= '0;
      best_found   <= 1'b0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (kind == KIND_CLEAR) begin
              valid        <= '0;
              fin_count    <= '0;
              valid_count  <= '0;
              current_time <= '0;
            end
            best_found <= 1'b0;
          end
        end
        S_LOAD: begin
          fin_count <= fin_count - CNT_W'(old_fin) + CNT_W'(ld_entry.burst == '0);
          if (!valid[ld_idx]) begin
            valid_count <= valid_count + CNT_W'(1);
          end
          valid[ld_idx] <= 1'b1;
        end
        S_SCAN: begin
          if (take) begin
            best_found <= 1'b1;
          end
        end
        S_DEC: begin
          current_time <= time_inc;
          if (finishing) begin
            fin_count <= fin_count + CNT_W'(1);
          end
        end
        S_TURN: begin
        end
        S_WAIT: begin
          done <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      ld_idx             <= SLOT_W'(slot);
      ld_entry.arrival   <= arrival_time;
      ld_entry.burst     <= burst_time;
      ld_entry.remaining <= burst_time;
      ld_entry.prio      <= priority_level;
      cnt                <= '0;
    end
    if (state == S_SCAN) begin
      cnt     <= cnt + SCAN_W'(1);
      chk_idx <= cnt[SLOT_W-1:0];
      if (take) begin
        best_idx <= chk_idx;
        best     <= rdata;
      end
    end
    if (state == S_TURN) begin
      turn <= (current_time > arr_ext) ? current_time - arr_ext : '0;
    end
    if (state == S_WAIT) begin
      wait_t     <= (turn > burst_ext) ? turn - burst_ext : '0;
      all_done_r <= fin_count == valid_count;
    end
  end

  assign busy            = state != S_IDLE;
  assign process_slot    = IN_SLOT_W'(best_idx);
  assign completion_time = current_time;
  assign waiting_time    = wait_t;
  assign turnaround_time = turn;
  assign all_done        = all_done_r;

endmodule

/* src/pps_checker.sv */
module pps_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic [pps_pkg::KIND_W-1:0]     kind,
  input logic                           done,
  input logic [pps_pkg::TIME_W-1:0]     waiting_time,
  input logic [pps_pkg::TIME_W-1:0]     turnaround_time
);
  import pps_pkg::*;

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_TICK) |=> busy)
    else $error("tick transfer did not start a scan");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_CLEAR) |=> (!busy && !done))
    else $error("clear transfer raised busy or a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result shown for more than one cycle");

  a_wait_le_turn: assert property (@(posedge clk) disable iff (rst)
    done |-> (waiting_time <= turnaround_time))
    else $error("waiting time exceeds turnaround time");

endmodule

bind preemptive_priority_scheduler_top pps_checker u_pps_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .kind            (kind),
  .done            (done),
  .waiting_time    (waiting_time),
  .turnaround_time (turnaround_time)
);
